// ===== sv/srg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srg_pkg
// Shared constants, lane type and fixed-point helpers for the sphere ray
// generator.
// ----------------------------------------------------------------------------
package srg_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int SAMPLE_W        = 16;
  localparam int DIR_W           = 16;
  localparam int COORD_W         = 32;
  localparam int RADIUS_W        = 31;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int Q30_W           = 31;
  localparam int SQRT_STEPS      = 31;
  localparam int HORNER_STEPS    = 5;

  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_Z = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RADIUS   = 2'd3;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;
  localparam logic [Q30_W-1:0]    Q30_ONE      = 31'h4000_0000;

  // One lane of the phase and polar pipeline.
  typedef struct packed {
    logic [Q30_W-1:0] s_arg;
    logic [Q30_W-1:0] c_arg;
    logic [Q30_W-1:0] s_t2;
    logic [Q30_W-1:0] c_t2;
    logic [Q30_W-1:0] s_acc;
    logic [Q30_W-1:0] c_acc;
    logic             s_neg;
    logic             c_neg;
    logic [Q30_W-1:0] ca;
    logic             ct_neg;
  } lane_t;

  // Odd polynomial for sin(pi/2 * t), Q30.
  function automatic logic [Q30_W-1:0] sin_coef(input int k);
    logic [Q30_W-1:0] c;
    case (k)
      0:       c = 31'd1686629713;
      1:       c = 31'd693598668;
      2:       c = 31'd85569306;
      3:       c = 31'd5026995;
      4:       c = 31'd172272;
      default: c = 31'd3864;
    endcase
    return c;
  endfunction

  // c - (acc*t2 >> 30), floored at zero.
  function automatic logic [Q30_W-1:0] horner_step(input logic [Q30_W-1:0] acc,
                                                   input logic [Q30_W-1:0] t2,
                                                   input logic [Q30_W-1:0] c);
    logic [2*Q30_W-1:0] pr;
    logic [Q30_W:0]     hi;
    pr = {{Q30_W{1'b0}}, acc} * {{Q30_W{1'b0}}, t2};
    hi = pr[2*Q30_W-1:30];
    return (hi >= {1'b0, c}) ? '0 : Q30_W'({1'b0, c} - hi);
  endfunction

  // acc*t >> 30, clamped to one.
  function automatic logic [Q30_W-1:0] horner_last(input logic [Q30_W-1:0] acc,
                                                   input logic [Q30_W-1:0] t);
    logic [2*Q30_W-1:0] pr;
    logic [Q30_W:0]     hi;
    pr = {{Q30_W{1'b0}}, acc} * {{Q30_W{1'b0}}, t};
    hi = pr[2*Q30_W-1:30];
    return (hi > {1'b0, Q30_ONE}) ? Q30_ONE : hi[Q30_W-1:0];
  endfunction

endpackage

// ===== sv/spherical_ray_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_ray_generator
// Maps a film sample pair to a uniform direction on the sphere and emits the
// ray direction (Q1.15) and origin (Q16.16) for a distant angular sensor.
// ----------------------------------------------------------------------------
// Depth: 36 register stages, with out_valid carried along a matching valid pipe.
// Throughput: one transaction per cycle while busy is low; the 31-stage
// square-root pipe sets the depth, the 31x31 multipliers set the stage timing.
// Reset (rst_n low, synchronous): drops every transaction in flight, clears
// target to zero and radius to one; busy is high only while reset is held.
// The receiver cannot stall: each result is shown for exactly one cycle.
module spherical_ray_generator #(
  parameter int SAMPLE_BITS = srg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [srg_pkg::SAMPLE_W-1:0]        in_sample_x,
  input  logic [srg_pkg::SAMPLE_W-1:0]        in_sample_y,
  output logic                                out_valid,
  output logic signed [srg_pkg::DIR_W-1:0]    out_dir_x,
  output logic signed [srg_pkg::DIR_W-1:0]    out_dir_y,
  output logic signed [srg_pkg::DIR_W-1:0]    out_dir_z,
  output logic signed [srg_pkg::COORD_W-1:0]  out_orig_x,
  output logic signed [srg_pkg::COORD_W-1:0]  out_orig_y,
  output logic signed [srg_pkg::COORD_W-1:0]  out_orig_z,
  input  logic                                cfg_we,
  input  logic [srg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [srg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int QW      = srg_pkg::Q30_W;
  localparam int NSTEP   = srg_pkg::SQRT_STEPS;
  localparam int LATENCY = NSTEP + 5;
  // Input bits above the sample width are ignored.
  localparam int MB = (SAMPLE_BITS < srg_pkg::SAMPLE_W) ? SAMPLE_BITS : srg_pkg::SAMPLE_W;
  localparam logic [srg_pkg::SAMPLE_W-1:0] SMASK =
    srg_pkg::SAMPLE_W'((33'd1 << MB) - 33'd1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [srg_pkg::COORD_W-1:0]  target_r [3];
  logic        [srg_pkg::RADIUS_W-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r[0] <= '0;
      target_r[1] <= '0;
      target_r[2] <= '0;
      radius_r    <= srg_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        srg_pkg::REG_TARGET_X: target_r[0] <= cfg_wdata;
        srg_pkg::REG_TARGET_Y: target_r[1] <= cfg_wdata;
        srg_pkg::REG_TARGET_Z: target_r[2] <= cfg_wdata;
        srg_pkg::REG_RADIUS:   radius_r    <= cfg_wdata[srg_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and valid pipe
  // --------------------------------------------------------------------------
  logic               accept;
  logic [LATENCY-1:0] vld_r;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LATENCY-2:0], accept};
    end
  end

  assign out_valid = vld_r[LATENCY-1];

  // --------------------------------------------------------------------------
  // Stage 1: phase to quadrant argument, polar cosine
  // --------------------------------------------------------------------------
  logic [srg_pkg::SAMPLE_W-1:0] x_m, y_m;
  logic [47:0]                  p_w, y_w;
  logic [31:0]                  p_s, p_c;
  logic signed [32:0]           cos_w;
  logic [QW-1:0]                s_arg, c_arg, ca;

  always_comb begin
    x_m   = in_sample_x & SMASK;
    y_m   = in_sample_y & SMASK;
    p_w   = 48'(x_m) << (32 - SAMPLE_BITS);
    y_w   = 48'(y_m) << (31 - SAMPLE_BITS);
    p_s   = p_w[31:0];
    p_c   = p_s + 32'h4000_0000;
    // Odd quadrants mirror the argument.
    s_arg = p_s[30] ? (srg_pkg::Q30_ONE - {1'b0, p_s[29:0]}) : {1'b0, p_s[29:0]};
    c_arg = p_c[30] ? (srg_pkg::Q30_ONE - {1'b0, p_c[29:0]}) : {1'b0, p_c[29:0]};
    cos_w = 33'sd1073741824 - $signed({1'b0, y_w[31:0]});
    ca    = cos_w[32] ? QW'(-cos_w) : cos_w[QW-1:0];
  end

  logic [QW-1:0] s1_sarg_r, s1_carg_r, s1_ca_r;
  logic          s1_sneg_r, s1_cneg_r, s1_ctneg_r;

  always_ff @(posedge clk) begin
    s1_sarg_r  <= s_arg;
    s1_carg_r  <= c_arg;
    s1_sneg_r  <= p_s[31];
    s1_cneg_r  <= p_c[31];
    s1_ca_r    <= ca;
    s1_ctneg_r <= cos_w[32];
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares for the polynomial and the sqrt radicand
  // --------------------------------------------------------------------------
  logic [2*QW-1:0] sq_s, sq_c, sq_ca;
  srg_pkg::lane_t  lane_r  [NSTEP+1];
  logic [61:0]     rem_r   [NSTEP+1];
  logic [61:0]     root_r  [NSTEP+1];

  always_comb begin
    sq_s  = {{QW{1'b0}}, s1_sarg_r} * {{QW{1'b0}}, s1_sarg_r};
    sq_c  = {{QW{1'b0}}, s1_carg_r} * {{QW{1'b0}}, s1_carg_r};
    sq_ca = {{QW{1'b0}}, s1_ca_r}   * {{QW{1'b0}}, s1_ca_r};
  end

  always_ff @(posedge clk) begin
    lane_r[0].s_arg  <= s1_sarg_r;
    lane_r[0].c_arg  <= s1_carg_r;
    lane_r[0].s_t2   <= sq_s[2*QW-2:30];
    lane_r[0].c_t2   <= sq_c[2*QW-2:30];
    lane_r[0].s_acc  <= srg_pkg::sin_coef(5);
    lane_r[0].c_acc  <= srg_pkg::sin_coef(5);
    lane_r[0].s_neg  <= s1_sneg_r;
    lane_r[0].c_neg  <= s1_cneg_r;
    lane_r[0].ca     <= s1_ca_r;
    lane_r[0].ct_neg <= s1_ctneg_r;
    rem_r[0]         <= (62'd1 << 60) - sq_ca;
    root_r[0]        <= '0;
  end

  // --------------------------------------------------------------------------
  // Stages 3..33: one sqrt digit per stage; the sine lanes run Horner in the
  // first six of them and then ride along.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * i);
    logic [61:0] trial;

    assign trial = root_r[i] + BIT;

    always_ff @(posedge clk) begin
      if (rem_r[i] >= trial) begin
        rem_r[i+1]  <= rem_r[i] - trial;
        root_r[i+1] <= (root_r[i] >> 1) + BIT;
      end else begin
        rem_r[i+1]  <= rem_r[i];
        root_r[i+1] <= root_r[i] >> 1;
      end
    end

    if (i < srg_pkg::HORNER_STEPS) begin : g_horner
      srg_pkg::lane_t lane_nxt;

      always_comb begin
        lane_nxt       = lane_r[i];
        lane_nxt.s_acc = srg_pkg::horner_step(lane_r[i].s_acc, lane_r[i].s_t2,
                                              srg_pkg::sin_coef(4 - i));
        lane_nxt.c_acc = srg_pkg::horner_step(lane_r[i].c_acc, lane_r[i].c_t2,
                                              srg_pkg::sin_coef(4 - i));
      end

      always_ff @(posedge clk) begin
        lane_r[i+1] <= lane_nxt;
      end
    end else if (i == srg_pkg::HORNER_STEPS) begin : g_last
      srg_pkg::lane_t lane_nxt;

      always_comb begin
        lane_nxt       = lane_r[i];
        lane_nxt.s_acc = srg_pkg::horner_last(lane_r[i].s_acc, lane_r[i].s_arg);
        lane_nxt.c_acc = srg_pkg::horner_last(lane_r[i].c_acc, lane_r[i].c_arg);
      end

      always_ff @(posedge clk) begin
        lane_r[i+1] <= lane_nxt;
      end
    end else begin : g_delay
      always_ff @(posedge clk) begin
        lane_r[i+1] <= lane_r[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 34: omega = (sin_t*cos_phi, sin_t*sin_phi, cos_t), magnitude + sign
  // --------------------------------------------------------------------------
  logic [QW-1:0]   sin_t;
  logic [2*QW-1:0] px, py;
  logic [QW-1:0]   wm_r  [3];
  logic            wneg_r [3];

  always_comb begin
    sin_t = root_r[NSTEP][QW-1:0];
    px    = {{QW{1'b0}}, sin_t} * {{QW{1'b0}}, lane_r[NSTEP].c_acc} + (62'd1 << 29);
    py    = {{QW{1'b0}}, sin_t} * {{QW{1'b0}}, lane_r[NSTEP].s_acc} + (62'd1 << 29);
  end

  always_ff @(posedge clk) begin
    wm_r[0]   <= px[2*QW-2:30];
    wm_r[1]   <= py[2*QW-2:30];
    wm_r[2]   <= lane_r[NSTEP].ca;
    wneg_r[0] <= lane_r[NSTEP].c_neg;
    wneg_r[1] <= lane_r[NSTEP].s_neg;
    wneg_r[2] <= lane_r[NSTEP].ct_neg;
  end

  // --------------------------------------------------------------------------
  // Stage 35: radius*|omega|, rounded direction
  // --------------------------------------------------------------------------
  logic [61:0]              rm_r   [3];
  logic                     rneg_r [3];
  logic signed [srg_pkg::DIR_W-1:0] dir_r [3];
  logic [31:0]              dsum   [3];
  logic [srg_pkg::DIR_W-1:0] dmag  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dsum[k] = {1'b0, wm_r[k]} + 32'd16384;
      dmag[k] = dsum[k][30:15];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      rm_r[k]   <= {{QW{1'b0}}, radius_r} * {{QW{1'b0}}, wm_r[k]};
      rneg_r[k] <= wneg_r[k];
      // Direction is minus omega; plus one saturates.
      if (wneg_r[k]) begin
        dir_r[k] <= dmag[k][15] ? 16'sh7fff : $signed(dmag[k]);
      end else begin
        dir_r[k] <= $signed(-dmag[k]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 36: origin = target +/- round(2*r*|omega|), saturated
  // --------------------------------------------------------------------------
  logic [63:0]        osum [3];
  logic signed [34:0] off  [3];
  logic signed [34:0] osat [3];
  logic signed [srg_pkg::COORD_W-1:0] orig_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      osum[k] = {1'b0, rm_r[k], 1'b0} + (64'd1 << 29);
      off[k]  = $signed({1'b0, osum[k][63:30]});
      osat[k] = 35'(target_r[k]) + (rneg_r[k] ? -off[k] : off[k]);
      if (osat[k] > 35'sd2147483647) begin
        orig_nxt[k] = 32'sh7fff_ffff;
      end else if (osat[k] < -35'sd2147483648) begin
        orig_nxt[k] = 32'sh8000_0000;
      end else begin
        orig_nxt[k] = osat[k][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_dir_x  <= dir_r[0];
    out_dir_y  <= dir_r[1];
    out_dir_z  <= dir_r[2];
    out_orig_x <= orig_nxt[0];
    out_orig_y <= orig_nxt[1];
    out_orig_z <= orig_nxt[2];
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##36 out_valid)
    else $error("accepted transaction did not emerge after the pipe latency");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("strobe right after reset");

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTEP+1] |-> (root_r[NSTEP] <= (62'd1 << 30)))
    else $error("polar sine root above one");

endmodule
